// ===== rtl/fhbp_pkg.sv =====
// Shared types, constants and the themed palette function for the fire blur block.
// Depends on nothing; the interfaces and the top level import it.
`default_nettype none

package fhbp_pkg;

  localparam int DEF_FRAME_WIDTH  = 320;
  localparam int DEF_FRAME_HEIGHT = 200;
  localparam int HEAT_W           = 8;
  localparam int THEME_W          = 2;
  localparam int SUM_W            = HEAT_W + 4;

  typedef enum logic [THEME_W-1:0] {
    PAL_RGB = 2'd0,
    PAL_RGR = 2'd1,
    PAL_GRB = 2'd2,
    PAL_BGR = 2'd3
  } theme_t;

  typedef struct packed {
    logic [HEAT_W-1:0] red;
    logic [HEAT_W-1:0] green;
    logic [HEAT_W-1:0] blue;
  } rgb_t;

  function automatic rgb_t palette(input logic [HEAT_W-1:0] h, input theme_t theme);
    logic [HEAT_W-1:0] r;
    logic [HEAT_W-1:0] g;
    logic [HEAT_W-1:0] b;
    rgb_t              c;
    r = '0;
    g = '0;
    b = '0;
    if (h > 8'd7 && h < 8'd32) begin
      r = 8'(8'd10 * (h - 8'd7));
    end
    if (h > 8'd31) begin
      r = 8'd255;
    end
    if (h > 8'd32 && h < 8'd57) begin
      g = 8'(8'd10 * (h - 8'd32));
    end
    if (h > 8'd56) begin
      g = 8'd255;
    end
    if (h < 8'd8) begin
      b = 8'(8'd8 * h);
    end
    if (h > 8'd7 && h < 8'd17) begin
      b = 8'(8'd8 * (8'd16 - h));
    end
    if (h > 8'd57 && h < 8'd82) begin
      b = 8'(8'd10 * (h - 8'd57));
    end
    if (h > 8'd81) begin
      b = 8'd255;
    end
    unique case (theme)
      PAL_RGR: c = '{red: r, green: g, blue: r};
      PAL_GRB: c = '{red: g, green: r, blue: b};
      PAL_BGR: c = '{red: b, green: g, blue: r};
      default: c = '{red: r, green: g, blue: b};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fhbp_if.sv =====
// Valid/ready channel interfaces for heat requests in and coloured pixels out.
// Depends on fhbp_pkg for the field widths.
`default_nettype none

interface fhbp_heat_if;
  import fhbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] heat_in;
  logic              frame_begin;

  modport source (output valid, output heat_in, output frame_begin, input ready);
  modport sink   (input valid, input heat_in, input frame_begin, output ready);
endinterface

interface fhbp_pix_if;
  import fhbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] heat_out;
  logic [HEAT_W-1:0] red;
  logic [HEAT_W-1:0] green;
  logic [HEAT_W-1:0] blue;
  logic              frame_first_out;

  modport source (output valid, output heat_out, output red, output green, output blue,
                  output frame_first_out, input ready);
  modport sink   (input valid, input heat_out, input red, input green, input blue,
                  input frame_first_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/fire_heat_blur_palette.sv =====
// Top level of the streaming fire blur with themed palette colour output.
// Depends on fhbp_pkg and the channel interfaces in fhbp_if.sv.
//
//   channel       role   carries
//   heat          sink   heat_in, frame_begin
//   pixel         source heat_out, red, green, blue, frame_first_out
//   color_theme   write  color_theme_we, color_theme_data
//
// One request per clock unless pixel stalls; any result is valid on the next cycle.
// The first FRAME_WIDTH+1 requests after reset fill the line memories and give no result.
// The loop through the previous result (left neighbour) runs through combinational adds.
// A stalled result holds its register; a new request is taken in the cycle it leaves.
// Reset is synchronous; the memories need no clearing pass.
`default_nettype none

module fire_heat_blur_palette #(
  parameter int FRAME_WIDTH  = fhbp_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = fhbp_pkg::DEF_FRAME_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         color_theme_we,
  input  wire logic [fhbp_pkg::THEME_W-1:0] color_theme_data,
  fhbp_heat_if.sink                         heat,
  fhbp_pix_if.source                        pixel
);
  import fhbp_pkg::*;

  localparam int LINE_LEN   = FRAME_WIDTH + 1;
  localparam int FILL_W     = $clog2(LINE_LEN + 1);
  localparam int OLD_DEPTH  = FRAME_WIDTH;
  localparam int OLD_AW     = $clog2(OLD_DEPTH);
  localparam int NEW_DEPTH  = FRAME_WIDTH - 1;
  localparam int NEW_AW     = $clog2(NEW_DEPTH);
  localparam int HIST_W     = $clog2(NEW_DEPTH + 1);
  localparam int FRAME_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int POS_W      = $clog2(FRAME_SIZE + 1);
  localparam int BLUR_LO    = 2 * FRAME_WIDTH;
  localparam int BLUR_HI    = FRAME_WIDTH * (FRAME_HEIGHT - 1);

  logic [THEME_W-1:0] theme;

  logic [HEAT_W:0]    old_mem [OLD_DEPTH];
  logic [HEAT_W:0]    old_rdata;
  logic [OLD_AW-1:0]  old_ptr;
  logic [OLD_AW-1:0]  old_ptr_next;

  logic [HEAT_W-1:0]  new_mem [NEW_DEPTH];
  logic [HEAT_W-1:0]  new_rdata;
  logic [NEW_AW-1:0]  new_ptr;
  logic [NEW_AW-1:0]  new_ptr_inc;
  logic [NEW_AW-1:0]  new_raddr;

  logic [FILL_W-1:0]  fill_cnt;
  logic [HIST_W-1:0]  hist_cnt;
  logic               hist_full;

  logic [HEAT_W-1:0]  centre;
  logic               centre_mark;
  logic [HEAT_W-1:0]  below;
  logic [HEAT_W-1:0]  up;
  logic [HEAT_W-1:0]  up_left;
  logic [HEAT_W-1:0]  left;
  logic [HEAT_W-1:0]  up_right;

  logic [POS_W-1:0]   pixel_position;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pixel_position_next;

  logic               out_valid;
  logic [HEAT_W-1:0]  out_heat;
  logic               out_mark;

  logic               fire;
  logic               filled;
  logic               produce;
  logic [SUM_W-1:0]   sum;
  logic [HEAT_W-1:0]  blurred;
  logic [HEAT_W-1:0]  result;
  rgb_t               colour;

  assign heat.ready = !out_valid || pixel.ready;
  assign fire       = heat.valid && heat.ready;
  assign filled     = (fill_cnt == FILL_W'(LINE_LEN));
  assign produce    = fire && filled;
  assign hist_full  = (hist_cnt == HIST_W'(NEW_DEPTH));

  assign old_ptr_next = (old_ptr == OLD_AW'(OLD_DEPTH - 1)) ? '0 : old_ptr + 1'b1;
  assign new_ptr_inc  = (new_ptr == NEW_AW'(NEW_DEPTH - 1)) ? '0 : new_ptr + 1'b1;
  assign new_raddr    = produce ? new_ptr_inc : new_ptr;
  assign up_right     = hist_full ? new_rdata : '0;

  always_comb begin
    pos = centre_mark ? '0 : pixel_position;
    pixel_position_next = (pos >= POS_W'(FRAME_SIZE)) ? POS_W'(FRAME_SIZE) : pos + 1'b1;
    sum = SUM_W'(up_left) + SUM_W'(up) + SUM_W'(up_right) + SUM_W'(left)
        + SUM_W'(centre) + SUM_W'(centre >> 1) + SUM_W'(centre >> 2)
        + SUM_W'(old_rdata[HEAT_W-1:0]) + SUM_W'(below);
    blurred = sum[HEAT_W+2:3];
    if (pos >= POS_W'(BLUR_LO) && pos < POS_W'(BLUR_HI)) begin
      result = blurred;
    end else begin
      result = centre;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      old_mem[old_ptr] <= {heat.frame_begin, heat.heat_in};
      old_rdata        <= old_mem[old_ptr_next];
      new_rdata        <= new_mem[new_raddr];
    end
    if (produce) begin
      new_mem[new_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      centre      <= old_rdata[HEAT_W-1:0];
      centre_mark <= old_rdata[HEAT_W];
      below       <= heat.heat_in;
    end
    if (produce) begin
      out_heat <= result;
      out_mark <= centre_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      theme          <= PAL_RGB;
      old_ptr        <= '0;
      new_ptr        <= '0;
      fill_cnt       <= '0;
      hist_cnt       <= '0;
      pixel_position <= '0;
      up             <= '0;
      up_left        <= '0;
      left           <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (color_theme_we) begin
        theme <= color_theme_data;
      end
      if (fire) begin
        old_ptr <= old_ptr_next;
        if (!filled) begin
          fill_cnt <= fill_cnt + 1'b1;
        end
      end
      if (produce) begin
        new_ptr        <= new_ptr_inc;
        pixel_position <= pixel_position_next;
        up             <= up_right;
        up_left        <= up;
        left           <= result;
        if (!hist_full) begin
          hist_cnt <= hist_cnt + 1'b1;
        end
        out_valid <= 1'b1;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign colour                = palette(out_heat, theme_t'(theme));
  assign pixel.valid           = out_valid;
  assign pixel.heat_out        = out_heat;
  assign pixel.red             = colour.red;
  assign pixel.green           = colour.green;
  assign pixel.blue            = colour.blue;
  assign pixel.frame_first_out = out_mark;

endmodule

`default_nettype wire
